FILE: design/sium_pkg.sv
// Package for the sorted interval union merger.
// Holds the record kinds, item functions, the sequencer states and the default capacity.
// Depends on nothing. Used by every other file in the design folder.
package sium_pkg;

   localparam int MAX_MEMBERS_DEFAULT = 32;

   localparam int CONTIG_W = 16;
   localparam int COORD_W  = 32;
   localparam int ID_W     = 32;
   localparam int NUM_W    = 32;

   typedef enum logic [0:0] {
      FUNC_REGION = 1'b0,
      FUNC_FLUSH  = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      KIND_UNION  = 2'd0,
      KIND_MEMBER = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_ERR,
      ST_CLOSE_HDR,
      ST_DRAIN_RD,
      ST_DRAIN_OUT,
      ST_OPEN,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_INS_CHECK,
      ST_SHIFT,
      ST_SHIFT_WR
   } state_type;

endpackage

FILE: design/sium_if.sv
// Valid/ready channel interfaces for the region items and the result items.
// Depends on sium_pkg for the field widths.
interface sium_req_if;
   logic                         valid;
   logic                         ready;
   logic                         func;
   logic [sium_pkg::ID_W-1:0]     region_id;
   logic [sium_pkg::CONTIG_W-1:0] contig_index;
   logic [sium_pkg::COORD_W-1:0]  region_start;
   logic [sium_pkg::COORD_W-1:0]  region_end;

   modport source (output valid, func, region_id, contig_index, region_start, region_end,
                   input ready);
   modport sink (input valid, func, region_id, contig_index, region_start, region_end,
                 output ready);
endinterface

interface sium_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   kind;
   logic [sium_pkg::NUM_W-1:0]    union_number;
   logic [sium_pkg::CONTIG_W-1:0] union_contig;
   logic [sium_pkg::COORD_W-1:0]  union_start;
   logic [sium_pkg::COORD_W-1:0]  union_end;
   logic [sium_pkg::ID_W-1:0]     member_id;
   logic                         ids_overflowed;
   logic                         last;

   modport source (output valid, kind, union_number, union_contig, union_start, union_end,
                   member_id, ids_overflowed, last, input ready);
   modport sink (input valid, kind, union_number, union_contig, union_start, union_end,
                 member_id, ids_overflowed, last, output ready);
endinterface

FILE: design/sorted_interval_union_merger.sv
// Top level of the sorted interval union merger: sequencer, union state, member id memory.
// Depends on sium_pkg and the channel interfaces in sium_if.sv.
// A region's id is compared with the stored ids in ascending order; a stored id is kept once,
// a new id shifts the larger ids up one place and is written in, a full store sets overflow.
// An error item yields one error result; a close sends the interval item, then one per member.
// One item is in work at a time. Reset is synchronous; memory is not cleared.
module sorted_interval_union_merger #(
   parameter int MAX_MEMBERS = sium_pkg::MAX_MEMBERS_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   sium_req_if.sink    req_chan,
   sium_rsp_if.source  rsp_chan
);

   localparam int IDX_W = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
   localparam int CNT_W = $clog2(MAX_MEMBERS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_MEMBERS);
   localparam logic [sium_pkg::NUM_W-1:0] NUM_ONE = {{(sium_pkg::NUM_W-1){1'b0}}, 1'b1};

   sium_pkg::state_type state_ff, state_in;

   logic                          open_ff, open_in;
   logic [sium_pkg::CONTIG_W-1:0] contig_ff, contig_in;
   logic [sium_pkg::COORD_W-1:0]  start_ff, start_in;
   logic [sium_pkg::COORD_W-1:0]  end_ff, end_in;
   logic [sium_pkg::NUM_W-1:0]    counter_ff, counter_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic                          ovf_ff, ovf_in;
   logic [CNT_W-1:0]              idx_ff, idx_in;
   logic [CNT_W-1:0]              shift_ff, shift_in;

   logic                          in_func_ff, in_func_in;
   logic [sium_pkg::ID_W-1:0]     in_id_ff, in_id_in;
   logic [sium_pkg::CONTIG_W-1:0] in_contig_ff, in_contig_in;
   logic [sium_pkg::COORD_W-1:0]  in_start_ff, in_start_in;
   logic [sium_pkg::COORD_W-1:0]  in_end_ff, in_end_in;

   logic [sium_pkg::ID_W-1:0]     mem [MAX_MEMBERS];
   logic [sium_pkg::ID_W-1:0]     rd_data_ff;
   logic                          rd_en;
   logic [IDX_W-1:0]              rd_addr;
   logic                          wr_en;
   logic [IDX_W-1:0]              wr_addr;
   logic [sium_pkg::ID_W-1:0]     wr_data;

   logic             req_fire;
   logic             rsp_fire;
   logic [CNT_W-1:0] idx_inc;
   logic [CNT_W-1:0] shift_dec;
   logic             drain_last;
   logic             is_flush;
   logic             must_close;
   sium_pkg::state_type after_close;

   assign req_fire   = req_chan.valid && req_chan.ready;
   assign rsp_fire   = rsp_chan.valid && rsp_chan.ready;
   assign idx_inc    = idx_ff + CNT_W'(1);
   assign shift_dec  = shift_ff - CNT_W'(1);
   assign drain_last = (idx_inc == count_ff);
   assign is_flush   = (in_func_ff == sium_pkg::FUNC_FLUSH);
   assign must_close = open_ff && ((in_contig_ff != contig_ff) || (in_start_ff > end_ff));
   assign after_close = is_flush ? sium_pkg::ST_IDLE : sium_pkg::ST_OPEN;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sium_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = sium_pkg::ST_DISPATCH;
            end
         end
         sium_pkg::ST_DISPATCH: begin
            priority if (is_flush) begin
               state_in = open_ff ? sium_pkg::ST_CLOSE_HDR : sium_pkg::ST_IDLE;
            end else if (in_end_ff < in_start_ff) begin
               state_in = sium_pkg::ST_ERR;
            end else if (must_close) begin
               state_in = sium_pkg::ST_CLOSE_HDR;
            end else begin
               state_in = sium_pkg::ST_OPEN;
            end
         end
         sium_pkg::ST_ERR: begin
            if (rsp_fire) begin
               state_in = sium_pkg::ST_IDLE;
            end
         end
         sium_pkg::ST_CLOSE_HDR: begin
            if (rsp_fire) begin
               state_in = (count_ff == '0) ? after_close : sium_pkg::ST_DRAIN_RD;
            end
         end
         sium_pkg::ST_DRAIN_RD: begin
            state_in = sium_pkg::ST_DRAIN_OUT;
         end
         sium_pkg::ST_DRAIN_OUT: begin
            if (rsp_fire) begin
               state_in = drain_last ? after_close : sium_pkg::ST_DRAIN_RD;
            end
         end
         sium_pkg::ST_OPEN: begin
            state_in = sium_pkg::ST_SRCH_RD;
         end
         sium_pkg::ST_SRCH_RD: begin
            state_in = (idx_ff == count_ff) ? sium_pkg::ST_INS_CHECK : sium_pkg::ST_SRCH_CMP;
         end
         sium_pkg::ST_SRCH_CMP: begin
            priority if (rd_data_ff < in_id_ff) begin
               state_in = sium_pkg::ST_SRCH_RD;
            end else if (rd_data_ff == in_id_ff) begin
               state_in = sium_pkg::ST_IDLE;
            end else begin
               state_in = sium_pkg::ST_INS_CHECK;
            end
         end
         sium_pkg::ST_INS_CHECK: begin
            state_in = (count_ff == CNT_MAX) ? sium_pkg::ST_IDLE : sium_pkg::ST_SHIFT;
         end
         sium_pkg::ST_SHIFT: begin
            state_in = (shift_ff == idx_ff) ? sium_pkg::ST_IDLE : sium_pkg::ST_SHIFT_WR;
         end
         sium_pkg::ST_SHIFT_WR: begin
            state_in = sium_pkg::ST_SHIFT;
         end
         default: begin
            state_in = sium_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs and memory controls.
   always_comb begin
      req_chan.ready          = 1'b0;
      rsp_chan.valid          = 1'b0;
      rsp_chan.kind           = sium_pkg::KIND_UNION;
      rsp_chan.union_number   = counter_ff;
      rsp_chan.union_contig   = contig_ff;
      rsp_chan.union_start    = start_ff;
      rsp_chan.union_end      = end_ff;
      rsp_chan.member_id      = '0;
      rsp_chan.ids_overflowed = ovf_ff;
      rsp_chan.last           = 1'b0;
      rd_en                   = 1'b0;
      rd_addr                 = idx_ff[IDX_W-1:0];
      wr_en                   = 1'b0;
      wr_addr                 = shift_ff[IDX_W-1:0];
      wr_data                 = rd_data_ff;
      unique case (state_ff)
         sium_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
         end
         sium_pkg::ST_ERR: begin
            rsp_chan.valid          = 1'b1;
            rsp_chan.kind           = sium_pkg::KIND_ERROR;
            rsp_chan.union_contig   = in_contig_ff;
            rsp_chan.union_start    = in_start_ff;
            rsp_chan.union_end      = in_end_ff;
            rsp_chan.member_id      = in_id_ff;
            rsp_chan.ids_overflowed = 1'b0;
            rsp_chan.last           = 1'b1;
         end
         sium_pkg::ST_CLOSE_HDR: begin
            rsp_chan.valid = 1'b1;
            rsp_chan.last  = (count_ff == '0);
         end
         sium_pkg::ST_DRAIN_RD: begin
            rd_en = 1'b1;
         end
         sium_pkg::ST_DRAIN_OUT: begin
            rsp_chan.valid     = 1'b1;
            rsp_chan.kind      = sium_pkg::KIND_MEMBER;
            rsp_chan.member_id = rd_data_ff;
            rsp_chan.last      = drain_last;
         end
         sium_pkg::ST_SRCH_RD: begin
            rd_en = (idx_ff != count_ff);
         end
         sium_pkg::ST_SHIFT: begin
            if (shift_ff == idx_ff) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff[IDX_W-1:0];
               wr_data = in_id_ff;
            end else begin
               rd_en   = 1'b1;
               rd_addr = shift_dec[IDX_W-1:0];
            end
         end
         sium_pkg::ST_SHIFT_WR: begin
            wr_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Next values of the union state and the working registers.
   always_comb begin
      open_in      = open_ff;
      contig_in    = contig_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      counter_in   = counter_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      idx_in       = idx_ff;
      shift_in     = shift_ff;
      in_func_in   = in_func_ff;
      in_id_in     = in_id_ff;
      in_contig_in = in_contig_ff;
      in_start_in  = in_start_ff;
      in_end_in    = in_end_ff;
      unique case (state_ff)
         sium_pkg::ST_IDLE: begin
            if (req_fire) begin
               in_func_in   = req_chan.func;
               in_id_in     = req_chan.region_id;
               in_contig_in = req_chan.contig_index;
               in_start_in  = req_chan.region_start;
               in_end_in    = req_chan.region_end;
            end
         end
         sium_pkg::ST_CLOSE_HDR: begin
            idx_in = '0;
            if (rsp_fire && (count_ff == '0)) begin
               counter_in = counter_ff + NUM_ONE;
               open_in    = 1'b0;
               ovf_in     = 1'b0;
            end
         end
         sium_pkg::ST_DRAIN_OUT: begin
            if (rsp_fire) begin
               if (drain_last) begin
                  counter_in = counter_ff + NUM_ONE;
                  open_in    = 1'b0;
                  count_in   = '0;
                  ovf_in     = 1'b0;
               end else begin
                  idx_in = idx_inc;
               end
            end
         end
         sium_pkg::ST_OPEN: begin
            idx_in = '0;
            if (!open_ff) begin
               open_in   = 1'b1;
               contig_in = in_contig_ff;
               start_in  = in_start_ff;
               end_in    = in_end_ff;
               count_in  = '0;
               ovf_in    = 1'b0;
            end else begin
               if (in_start_ff < start_ff) begin
                  start_in = in_start_ff;
               end
               if (in_end_ff > end_ff) begin
                  end_in = in_end_ff;
               end
            end
         end
         sium_pkg::ST_SRCH_CMP: begin
            if (rd_data_ff < in_id_ff) begin
               idx_in = idx_inc;
            end
         end
         sium_pkg::ST_INS_CHECK: begin
            if (count_ff == CNT_MAX) begin
               ovf_in = 1'b1;
            end else begin
               shift_in = count_ff;
            end
         end
         sium_pkg::ST_SHIFT: begin
            if (shift_ff == idx_ff) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         sium_pkg::ST_SHIFT_WR: begin
            shift_in = shift_dec;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sium_pkg::ST_IDLE;
         open_ff    <= 1'b0;
         counter_ff <= '0;
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         open_ff    <= open_in;
         counter_ff <= counter_in;
         count_ff   <= count_in;
         ovf_ff     <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      contig_ff    <= contig_in;
      start_ff     <= start_in;
      end_ff       <= end_in;
      idx_ff       <= idx_in;
      shift_ff     <= shift_in;
      in_func_ff   <= in_func_in;
      in_id_ff     <= in_id_in;
      in_contig_ff <= in_contig_in;
      in_start_ff  <= in_start_in;
      in_end_ff    <= in_end_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

FILE: design/sium_checker.sv
// Port-level checks for the sorted interval union merger, and the bind that attaches them.
// Depends on sium_pkg and on the top level sorted_interval_union_merger.
module sium_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [1:0]                rsp_kind,
   input logic [sium_pkg::ID_W-1:0] rsp_member_id,
   input logic                      rsp_last
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("The block took a second item right after accepting one.");

   a_no_accept_while_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("The block was ready for an item while a result item waited.");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == sium_pkg::KIND_ERROR)) |-> rsp_last)
      else $error("An error item was not marked last.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_kind) && $stable(rsp_member_id) && $stable(rsp_last)))
      else $error("A stalled result item changed or was withdrawn.");

endmodule

bind sorted_interval_union_merger sium_checker u_sium_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_kind      (rsp_chan.kind),
   .rsp_member_id (rsp_chan.member_id),
   .rsp_last      (rsp_chan.last)
);
